// File: hdl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, skipped while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rmcu_pkg.sv
package rmcu_pkg;

  localparam int unsigned DRAW_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned COV_W  = 64;
  localparam int unsigned ACC_W  = 128;

  typedef enum logic [1:0] {
    SRC_MEAN,
    SRC_COV
  } src_t;

  // Datapath command issued by the controller for one result element.
  typedef struct packed {
    logic             start;   // launch one element computation
    src_t             src;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } rmcu_cmd_t;

  typedef struct packed {
    logic done;                // element result ready this cycle
  } rmcu_sts_t;

endpackage

// File: hdl/rmcu_divider.sv
// Restoring divider: 128-bit signed dividend by 24-bit unsigned divisor,
// one quotient bit a cycle, round half away from zero, saturate to
// 32 or 64 bits.
module rmcu_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [rmcu_pkg::ACC_W-1:0] dividend,
  input  logic [rmcu_pkg::CNT_W-1:0]    divisor,
  input  logic                          narrow,   // 1: saturate to 32 bits
  output logic                          done,
  output logic [rmcu_pkg::COV_W-1:0]    quotient
);

  localparam int unsigned AW = rmcu_pkg::ACC_W;
  localparam int unsigned DW = rmcu_pkg::CNT_W;

  logic          busy_r, busy_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic          neg_r, narrow_r;
  logic          done_r, done_nxt;
  logic [rmcu_pkg::COV_W-1:0] quo_r, quo_nxt;

  logic [DW+1:0] trial;
  logic [DW+1:0] shifted;
  logic [AW:0]   qround;
  logic [DW+1:0] rem2;
  logic [63:0]   maxv;
  logic          ovf;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    shifted  = {rem_r, q_r[AW-1]};
    trial    = shifted - {2'b00, d_r};
    rem2     = {rem_r, 1'b0};
    qround   = {1'b0, q_r} + {{AW{1'b0}}, (rem2 >= {2'b00, d_r})};
    maxv     = narrow_r ? 64'h0000_0000_7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
    ovf      = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 8'(AW);
      q_nxt    = dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != 8'd0) begin
        if (!trial[DW+1]) begin
          rem_nxt = trial[DW:0];
          q_nxt   = {q_r[AW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[DW:0];
          q_nxt   = {q_r[AW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 8'd1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!neg_r) begin
          ovf = (qround[AW:64] != '0) || (qround[63:0] > maxv);
          quo_nxt = ovf ? maxv : qround[63:0];
        end else begin
          ovf = (qround[AW:64] != '0) || (qround[63:0] > maxv + 64'd1);
          quo_nxt = ovf ? -(maxv + 64'd1) : -qround[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r      <= divisor;
      neg_r    <= dividend[AW-1];
      narrow_r <= narrow;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/rmcu_datapath.sv
// Storage and arithmetic: sample buffer, mean and covariance stores,
// one 32x32 multiplier stage feeding a 128-bit accumulator, shared divider.
module rmcu_datapath #(
  parameter int unsigned N = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [rmcu_pkg::IDX_W-1:0]         wr_idx,
  input  logic signed [rmcu_pkg::DRAW_W-1:0] wr_data,
  input  logic                               load_n,
  input  logic [rmcu_pkg::CNT_W-1:0]         n_in,
  input  logic                               snap_mean,
  input  rmcu_pkg::rmcu_cmd_t                cmd,
  output rmcu_pkg::rmcu_sts_t                sts,
  output logic [rmcu_pkg::COV_W-1:0]         value
);

  localparam int unsigned NN = N * N;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = (NN > 1) ? $clog2(NN) : 1;
  localparam int unsigned AW = rmcu_pkg::ACC_W;

  typedef enum logic [2:0] {
    P_IDLE, P_T0, P_T1, P_T2, P_T3, P_DIV, P_WAIT
  } phase_t;

  logic signed [31:0] sbuf_r [N];
  logic signed [31:0] mean_r [N];
  logic signed [31:0] omean_r [N];
  logic signed [63:0] cov_r [NN];
  logic [N-1:0]       mvalid_r;
  logic [NN-1:0]      cvalid_r;
  logic [rmcu_pkg::CNT_W-1:0] n_r;

  phase_t        ph_r;
  logic          h_r;
  logic [IW-1:0] ri_r, ci_r;
  logic          is_cov_r;
  logic signed [AW-1:0] acc_r;
  logic signed [63:0]   prod_r;
  logic signed [63:0]   prod_r_nxt_c;
  logic signed [63:0]   op64;
  logic [24:0]          opk;
  logic signed [32:0]   mul_a;
  logic signed [25:0]   mul_b;
  logic signed [58:0]   mul_p;
  logic signed [AW-1:0] term;
  logic                 div_start, div_done;
  logic [63:0]          div_q;
  logic [rmcu_pkg::CNT_W-1:0] div_d;
  logic [CW-1:0]        cidx;
  logic [IW-1:0]        er, ec;
  logic [CW-1:0]        eidx;

  logic signed [31:0] mi, mj, oi, oj, si, sj, em;
  logic signed [63:0] cij;

  assign cidx = CW'(ri_r * N + ci_r);
  assign mi  = mvalid_r[ri_r] ? mean_r[ri_r] : '0;
  assign mj  = mvalid_r[ci_r] ? mean_r[ci_r] : '0;
  assign oi  = omean_r[ri_r];
  assign oj  = omean_r[ci_r];
  assign si  = sbuf_r[ri_r];
  assign sj  = sbuf_r[ci_r];
  assign cij = cvalid_r[cidx] ? cov_r[cidx] : '0;

  // at most one 32x32 product per term, registered before the scaling multiply
  always_comb begin
    prod_r_nxt_c = '0;
    op64 = '0;
    opk  = '0;
    case (ph_r)
      P_T0: begin
        if (is_cov_r) begin
          prod_r_nxt_c = 64'(oi) * 64'(oj);
        end else begin
          prod_r_nxt_c = 64'(oi);
        end
      end
      P_T1: begin
        prod_r_nxt_c = is_cov_r ? 64'(si) * 64'(sj) : 64'(si);
      end
      P_T2: begin
        prod_r_nxt_c = 64'(mi) * 64'(mj);
      end
      default: prod_r_nxt_c = '0;
    endcase
    case (ph_r)
      P_T1: begin op64 = prod_r; opk = 25'(n_r) - 25'd1; end
      P_T2: begin op64 = prod_r; opk = 25'd1; end
      P_T3: begin op64 = -prod_r; opk = 25'(n_r); end
      default: begin op64 = cij; opk = 25'(n_r) - 25'd2; end
    endcase
    // low half unsigned first, then the signed high half weighted by 2^32
    mul_a = h_r ? {op64[63], op64[63:32]} : {1'b0, op64[31:0]};
    mul_b = $signed({1'b0, opk});
    mul_p = mul_a * mul_b;
    term  = h_r ? {{37{mul_p[58]}}, mul_p, 32'h0000_0000} : {{69{mul_p[58]}}, mul_p};
  end

  assign div_d     = is_cov_r ? n_r - 24'd1 : n_r;
  assign div_start = (ph_r == P_DIV);

  rmcu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (div_d),
    .narrow   (!is_cov_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx < rmcu_pkg::IDX_W'(N))) begin
      sbuf_r[wr_idx[IW-1:0]] <= wr_data;
    end
    if (load_n) begin
      n_r <= n_in;
    end
    if (snap_mean) begin
      for (int k = 0; k < N; k++) begin
        omean_r[k] <= mvalid_r[k] ? mean_r[k] : '0;
      end
    end
    // hold the product over both halves of a term
    if (h_r) begin
      prod_r <= prod_r_nxt_c;
    end
    case (ph_r)
      P_IDLE: begin
        if (cmd.start) begin
          ri_r     <= cmd.row[IW-1:0];
          ci_r     <= cmd.col[IW-1:0];
          is_cov_r <= (cmd.src == rmcu_pkg::SRC_COV);
          acc_r    <= '0;
        end
      end
      P_T0: if (is_cov_r) acc_r <= acc_r + term;
      P_T1: acc_r <= acc_r + term;
      P_T2: acc_r <= acc_r + term;
      P_T3: acc_r <= acc_r + term;
      default: ;
    endcase
    if (!rst_n) begin
      ph_r     <= P_IDLE;
      h_r      <= 1'b0;
      mvalid_r <= '0;
      cvalid_r <= '0;
    end else begin
      case (ph_r)
        P_IDLE: if (cmd.start) ph_r <= P_T0;
        P_T0: begin
          h_r <= !h_r;
          if (h_r) ph_r <= P_T1;
        end
        P_T1: begin
          h_r <= !h_r;
          if (h_r) ph_r <= P_T2;
        end
        P_T2: begin
          h_r <= !h_r;
          if (h_r) ph_r <= is_cov_r ? P_T3 : P_DIV;
        end
        P_T3: begin
          h_r <= !h_r;
          if (h_r) ph_r <= P_DIV;
        end
        P_DIV:  ph_r <= P_WAIT;
        P_WAIT: begin
          if (div_done) begin
            ph_r <= P_IDLE;
            if (is_cov_r) begin
              cov_r[cidx]    <= (n_r < 24'd2) ? '0 : div_q;
              cvalid_r[cidx] <= 1'b1;
            end else begin
              mean_r[ri_r]   <= (n_r == '0) ? '0 : div_q[31:0];
              mvalid_r[ri_r] <= 1'b1;
            end
          end
        end
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sts.done <= 1'b0;
    end else begin
      sts.done <= (ph_r == P_WAIT) && div_done;
    end
  end

  // result read-out follows the row and column the controller presents
  assign er   = cmd.row[IW-1:0];
  assign ec   = cmd.col[IW-1:0];
  assign eidx = CW'(er * N + ec);
  assign em   = mvalid_r[er] ? mean_r[er] : '0;

  assign value = (cmd.src == rmcu_pkg::SRC_COV) ? (cvalid_r[eidx] ? cov_r[eidx] : '0)
                                                : {{16{em[31]}}, em, 16'h0000};

endmodule

// File: hdl/rmcu_ctrl.sv
// Sequencer: after the last element, computes the means then each
// covariance entry, then streams all results out.
module rmcu_ctrl #(
  parameter int unsigned N = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic                       in_last,
  output logic                       in_ready,
  output logic                       snap_mean,
  output rmcu_pkg::rmcu_cmd_t        cmd,
  input  rmcu_pkg::rmcu_sts_t        sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kind,
  output logic [rmcu_pkg::IDX_W-1:0] out_row,
  output logic [rmcu_pkg::IDX_W-1:0] out_col,
  output logic                       out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_MISSUE, S_MWAIT, S_CISSUE, S_CWAIT, S_EMIT
  } state_t;

  localparam logic [rmcu_pkg::IDX_W-1:0] LAST = rmcu_pkg::IDX_W'(N - 1);

  state_t state_r;
  logic [rmcu_pkg::IDX_W-1:0] r_r, c_r;
  logic kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      r_r       <= '0;
      c_r       <= '0;
      kind_r    <= 1'b0;
      snap_mean <= 1'b0;
    end else begin
      snap_mean <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_last) begin
            state_r   <= S_MISSUE;
            snap_mean <= 1'b1;
            r_r       <= '0;
            c_r       <= '0;
          end
        end
        S_MISSUE: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (sts.done) begin
            if (r_r == LAST) begin
              r_r     <= '0;
              state_r <= S_CISSUE;
            end else begin
              r_r     <= r_r + 1'b1;
              state_r <= S_MISSUE;
            end
          end
        end
        S_CISSUE: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (sts.done) begin
            state_r <= S_CISSUE;
            if (c_r == LAST) begin
              c_r <= '0;
              if (r_r == LAST) begin
                r_r     <= '0;
                kind_r  <= 1'b0;
                state_r <= S_EMIT;
              end else begin
                r_r <= r_r + 1'b1;
              end
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (!kind_r) begin
              if (r_r == LAST) begin
                r_r    <= '0;
                kind_r <= 1'b1;
              end else begin
                r_r <= r_r + 1'b1;
              end
            end else if (c_r == LAST) begin
              c_r <= '0;
              if (r_r == LAST) begin
                state_r <= S_IDLE;
                r_r     <= '0;
                kind_r  <= 1'b0;
              end else begin
                r_r <= r_r + 1'b1;
              end
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.start = (state_r == S_MISSUE) || (state_r == S_CISSUE);
    cmd.src   = rmcu_pkg::SRC_MEAN;
    cmd.row   = r_r;
    cmd.col   = '0;
    // address the covariance store when issuing or emitting its entries
    if ((state_r == S_CISSUE) || ((state_r == S_EMIT) && kind_r)) begin
      cmd.src = rmcu_pkg::SRC_COV;
      cmd.col = c_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_kind  = kind_r;
  assign out_row   = r_r;
  assign out_col   = kind_r ? c_r : '0;
  assign out_last  = kind_r && (r_r == LAST) && (c_r == LAST);

endmodule

// File: hdl/running_mean_covariance_update_core.sv
// Channel | Dir | Request payload
// in_     | in  | draw_value, element_index, last_element, iteration
// out_    | out | result_kind, row_index, col_index, result_value, last_result
//
// A non-last element is taken while the core is idle. The last element
// starts N mean and N*N covariance updates, each paced by the bit-serial
// divider (one quotient bit a cycle over a 128-bit numerator). Input is
// held off until every result has left. Results then stream at one per
// cycle while out_tready is high. Reset is synchronous, active low; mean
// and covariance read as zero after it.
module running_mean_covariance_update_core #(
  parameter int unsigned VECTOR_SIZE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // draw_value[31:0], element_index[34:32],
                                  // iteration[58:35]
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // row_index[2:0], col_index[5:3],
                                  // result_value[69:6]
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // last_result
);

  logic                in_fire;
  logic                snap_mean;
  rmcu_pkg::rmcu_cmd_t cmd;
  rmcu_pkg::rmcu_sts_t sts;
  logic [63:0]         value;
  logic [2:0]          orow, ocol;

  assign in_fire = in_tvalid && in_tready;

  rmcu_ctrl #(.N(VECTOR_SIZE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .snap_mean (snap_mean),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_row   (orow),
    .out_col   (ocol),
    .out_last  (out_tlast)
  );

  rmcu_datapath #(.N(VECTOR_SIZE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_fire),
    .wr_idx    (in_tdata[34:32]),
    .wr_data   (in_tdata[31:0]),
    .load_n    (in_fire && in_tlast),
    .n_in      (in_tdata[58:35]),
    .snap_mean (snap_mean),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value)
  );

  assign out_tdata = {2'b00, value, ocol, orow};

endmodule

// File: hdl/rmcu_checker.sv
`include "assert_macros.svh"

module rmcu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic        out_tuser,
  input logic [71:0] out_tdata
);

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken during output")
  `ASSERT_IMPL(a_last_is_cov, clk, rst_n, out_tvalid && out_tlast, out_tuser, "last not covariance")
  `ASSERT_IMPL(a_mean_col0, clk, rst_n, out_tvalid && !out_tuser, out_tdata[5:3] == 3'd0, "mean col nonzero")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind running_mean_covariance_update_core rmcu_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
